// ----- src/hdp_pkg.sv -----
// ----------------------------------------------------------------------------
// hdp_pkg
// shared constants, status codes, result type and month lookup for the
// http date parser
// ----------------------------------------------------------------------------
package hdp_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned FieldW  = 7;
  localparam int unsigned PosW    = 5;

  localparam logic [PosW-1:0] DateLen = PosW'(29);
  localparam logic [PosW-1:0] PosSat  = PosW'(30);

  localparam logic [StatusW-1:0] StOk    = 3'd0;
  localparam logic [StatusW-1:0] StShort = 3'd1;
  localparam logic [StatusW-1:0] StComma = 3'd2;
  localparam logic [StatusW-1:0] StMonth = 3'd3;
  localparam logic [StatusW-1:0] StDigit = 3'd4;
  localparam logic [StatusW-1:0] StTz    = 3'd5;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [FieldW-1:0]  day;
    logic [FieldW-1:0]  hour;
    logic [FieldW-1:0]  minute;
    logic [FieldW-1:0]  second;
  } hdp_result_t;

  // three characters in string order, first character in the top byte
  function automatic logic [MonthW-1:0] month_lookup(input logic [3*CharW-1:0] name);
    logic [MonthW-1:0] m;
    unique case (name)
      "Jan":   m = 4'd1;
      "Feb":   m = 4'd2;
      "Mar":   m = 4'd3;
      "Apr":   m = 4'd4;
      "May":   m = 4'd5;
      "Jun":   m = 4'd6;
      "Jul":   m = 4'd7;
      "Aug":   m = 4'd8;
      "Sep":   m = 4'd9;
      "Oct":   m = 4'd10;
      "Nov":   m = 4'd11;
      "Dec":   m = 4'd12;
      default: m = 4'd0;
    endcase
    return m;
  endfunction

endpackage

// ----- src/hdp_core.sv -----
// ----------------------------------------------------------------------------
// hdp_core
// per-byte parse state: position, first error, month and numeric fields;
// forms the result for the word that carries the last mark
// ----------------------------------------------------------------------------
module hdp_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [hdp_pkg::CharW-1:0]  char_i,
  input  logic                       last_i,
  output hdp_pkg::hdp_result_t       result_o
);
  import hdp_pkg::*;

  logic [PosW-1:0]    pos_q, pos_d;
  logic [StatusW-1:0] err_q, err_d;
  logic [2*CharW-1:0] mchars_q, mchars_d;
  logic [MonthW-1:0]  month_q, month_d;
  logic [YearW-1:0]   year_q, year_d;
  logic [FieldW-1:0]  fld_q [4];
  logic [FieldW-1:0]  fld_d [4];

  logic               digit;
  logic [3:0]         dval;
  logic [StatusW-1:0] flag;
  logic               slot_hit;
  logic [1:0]         slot;
  logic [MonthW-1:0]  mlook;
  logic [PosW:0]      count;
  logic [StatusW-1:0] status;

  assign digit = (char_i >= "0") && (char_i <= "9");
  assign dval  = 4'(char_i - "0");
  assign mlook = month_lookup({mchars_q[CharW-1:0], mchars_q[2*CharW-1:CharW], char_i});

  always_comb begin
    slot_hit = 1'b1;
    unique case (pos_q)
      5'd5, 5'd6:   slot = 2'd0;
      5'd17, 5'd18: slot = 2'd1;
      5'd20, 5'd21: slot = 2'd2;
      5'd23, 5'd24: slot = 2'd3;
      default: begin
        slot     = 2'd0;
        slot_hit = 1'b0;
      end
    endcase
  end

  always_comb begin
    flag     = StOk;
    mchars_d = mchars_q;
    month_d  = month_q;
    year_d   = year_q;
    for (int i = 0; i < 4; i++) fld_d[i] = fld_q[i];
    if (pos_q == 5'd3) begin
      if (char_i != ",") flag = StComma;
    end else if (pos_q == 5'd4) begin
      if (char_i != " ") flag = StComma;
    end else if (slot_hit) begin
      if (!digit) flag = StDigit;
      else fld_d[slot] = FieldW'({fld_q[slot], 3'b000} + {fld_q[slot], 1'b0} + FieldW'(dval));
    end else if (pos_q == 5'd8) begin
      mchars_d = {8'h00, char_i};
    end else if (pos_q == 5'd9) begin
      mchars_d = {char_i, mchars_q[CharW-1:0]};
    end else if (pos_q == 5'd10) begin
      month_d = mlook;
      if (mlook == '0) flag = StMonth;
    end else if (pos_q >= 5'd12 && pos_q <= 5'd15) begin
      if (!digit) flag = StDigit;
      else year_d = YearW'({year_q, 3'b000} + {year_q, 1'b0} + YearW'(dval));
    end else if (pos_q == 5'd26) begin
      if (char_i != "G") flag = StTz;
    end else if (pos_q == 5'd27) begin
      if (char_i != "M") flag = StTz;
    end else if (pos_q == 5'd28) begin
      if (char_i != "T") flag = StTz;
    end else if (pos_q >= DateLen) begin
      flag = StTz;
    end
    err_d = (err_q == StOk) ? flag : err_q;
    pos_d = (pos_q == PosSat) ? PosSat : pos_q + 5'd1;
  end

  assign count  = {1'b0, pos_q} + 6'd1;
  assign status = (count < {1'b0, DateLen}) ? StShort : err_d;

  always_comb begin
    result_o        = '0;
    result_o.status = status;
    if (status == StOk) begin
      result_o.year   = year_q;
      result_o.month  = month_q;
      result_o.day    = fld_q[0];
      result_o.hour   = fld_q[1];
      result_o.minute = fld_q[2];
      result_o.second = fld_q[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      err_q    <= StOk;
      mchars_q <= '0;
      month_q  <= '0;
      year_q   <= '0;
      for (int i = 0; i < 4; i++) fld_q[i] <= '0;
    end else if (step_i) begin
      if (last_i) begin
        pos_q    <= '0;
        err_q    <= StOk;
        mchars_q <= '0;
        month_q  <= '0;
        year_q   <= '0;
        for (int i = 0; i < 4; i++) fld_q[i] <= '0;
      end else begin
        pos_q    <= pos_d;
        err_q    <= err_d;
        mchars_q <= mchars_d;
        month_q  <= month_d;
        year_q   <= year_d;
        for (int i = 0; i < 4; i++) fld_q[i] <= fld_d[i];
      end
    end
  end

  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosSat)
    else $error("position count beyond saturation");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !last_i && err_q != StOk |=> err_q == $past(err_q))
    else $error("first error overwritten");

  a_pos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> pos_q == '0 && err_q == StOk)
    else $error("parse state not cleared after last word");

endmodule

// ----- src/http_date_parser.sv -----
// ----------------------------------------------------------------------------
// http_date_parser
// streaming parser for rfc 1123 http dates, one character per word
// ----------------------------------------------------------------------------
// input channel: one character per word (char_byte_i) with last_char_i set on
// the final character of a date string. output channel: one result word per
// string, with status and the parsed year, month, day, hour, minute, second;
// all value fields are zero when status is not ok.
// an accepted character goes into an input register, is parsed from there by
// short logic and, if it carries the last mark, lands in the result register,
// which drives the result channel.
// throughput is one character per cycle while the result receiver does not stall, set by the single parse stage.
// reset clears the parse state and both valid flags; after each string the
// parse state returns to its reset value for the next string.
// when the receiver stalls, the result register holds and the input register
// stops advancing once it holds a word; input ready falls one word later and
// comes back as soon as the result is taken.
// ----------------------------------------------------------------------------
module http_date_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [hdp_pkg::CharW-1:0]   char_byte_i,
  input  logic                        last_char_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hdp_pkg::StatusW-1:0] status_o,
  output logic [hdp_pkg::YearW-1:0]   year_value_o,
  output logic [hdp_pkg::MonthW-1:0]  month_value_o,
  output logic [hdp_pkg::FieldW-1:0]  day_value_o,
  output logic [hdp_pkg::FieldW-1:0]  hour_value_o,
  output logic [hdp_pkg::FieldW-1:0]  minute_value_o,
  output logic [hdp_pkg::FieldW-1:0]  second_value_o
);
  import hdp_pkg::*;

  logic             s1_valid_q;
  logic [CharW-1:0] s1_char_q;
  logic             s1_last_q;
  logic             out_valid_q;
  hdp_result_t      res_q;
  hdp_result_t      res_d;
  logic             advance;
  logic             step;

  assign advance    = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;

  hdp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .char_i   (s1_char_q),
    .last_i   (s1_last_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_char_q <= char_byte_i;
      s1_last_q <= last_char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && s1_last_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = res_q.status;
  assign year_value_o   = res_q.year;
  assign month_value_o  = res_q.month;
  assign day_value_o    = res_q.day;
  assign hour_value_o   = res_q.hour;
  assign minute_value_o = res_q.minute;
  assign second_value_o = res_q.second;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StOk |-> year_value_o == '0 && month_value_o == '0
      && day_value_o == '0 && hour_value_o == '0 && minute_value_o == '0
      && second_value_o == '0)
    else $error("value fields not cleared on error status");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_char_q) && $stable(s1_last_q))
    else $error("input register lost a word while stalled");

  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !s1_last_q |=> !out_valid_q)
    else $error("result without a last character");

endmodule

// ----- bench/http_date_parser_tb.sv -----
// ----------------------------------------------------------------------------
// http_date_parser_tb
// self-checking bench for the streaming rfc 1123 date parser: directed dates,
// format errors and long strings, then mostly well-formed random dates with
// mutations and noise strings; a local parse model predicts each result word,
// and random gaps and stalls hit both handshakes
// ----------------------------------------------------------------------------
module http_date_parser_tb;
  import hdp_pkg::*;

  typedef logic [CharW-1:0] char_q_t[$];

  localparam int unsigned IdleLimit = 1000;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [CharW-1:0]   char_byte_i    = '0;
  logic               last_char_i    = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic [StatusW-1:0] status_o;
  logic [YearW-1:0]   year_value_o;
  logic [MonthW-1:0]  month_value_o;
  logic [FieldW-1:0]  day_value_o;
  logic [FieldW-1:0]  hour_value_o;
  logic [FieldW-1:0]  minute_value_o;
  logic [FieldW-1:0]  second_value_o;

  // parse state of the model
  logic [PosW-1:0]    pos_q;
  logic [StatusW-1:0] err_q;
  logic [15:0]        mon_chars_q;
  logic [MonthW-1:0]  mon_found_q;
  logic [YearW-1:0]   year_q;
  logic [FieldW-1:0]  fld_q [4];

  logic [23:0] month_names [12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
                                    "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};

  hdp_result_t date_q[$];
  hdp_result_t want;
  int          errors     = 0;
  int          chars_sent = 0;
  int          idle_cycles = 0;
  bit          no_idle    = 1'b0;

  http_date_parser u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_byte_i    (char_byte_i),
    .last_char_i    (last_char_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .year_value_o   (year_value_o),
    .month_value_o  (month_value_o),
    .day_value_o    (day_value_o),
    .hour_value_o   (hour_value_o),
    .minute_value_o (minute_value_o),
    .second_value_o (second_value_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic clear_parse();
    pos_q       = '0;
    err_q       = StOk;
    mon_chars_q = '0;
    mon_found_q = '0;
    year_q      = '0;
    for (int i = 0; i < 4; i++) fld_q[i] = '0;
  endtask

  task automatic note_error(input logic [StatusW-1:0] code);
    if (err_q == StOk) err_q = code;
  endtask

  task automatic parse_char(input logic [CharW-1:0] c, input logic last);
    logic        is_digit;
    int          dig;
    int          slot;
    int          count;
    hdp_result_t res;
    logic [StatusW-1:0] st;
    is_digit = (c >= "0") && (c <= "9");
    dig      = int'(c) - int'(8'h30);
    case (pos_q)
      5, 6:    slot = 0;
      17, 18:  slot = 1;
      20, 21:  slot = 2;
      23, 24:  slot = 3;
      default: slot = -1;
    endcase
    if (pos_q == 3) begin
      if (c != ",") note_error(StComma);
    end else if (pos_q == 4) begin
      if (c != " ") note_error(StComma);
    end else if (slot >= 0) begin
      if (!is_digit) note_error(StDigit);
      else fld_q[slot] = FieldW'(int'(fld_q[slot]) * 10 + dig);
    end else if (pos_q == 8) begin
      mon_chars_q = {8'h00, c};
    end else if (pos_q == 9) begin
      mon_chars_q = {c, mon_chars_q[7:0]};
    end else if (pos_q == 10) begin
      mon_found_q = '0;
      for (int m = 0; m < 12; m++) begin
        if (mon_found_q == 0 && {mon_chars_q[7:0], mon_chars_q[15:8], c} == month_names[m])
          mon_found_q = MonthW'(m + 1);
      end
      if (mon_found_q == 0) note_error(StMonth);
    end else if (pos_q >= 12 && pos_q <= 15) begin
      if (!is_digit) note_error(StDigit);
      else year_q = YearW'(int'(year_q) * 10 + dig);
    end else if (pos_q == 26) begin
      if (c != "G") note_error(StTz);
    end else if (pos_q == 27) begin
      if (c != "M") note_error(StTz);
    end else if (pos_q == 28) begin
      if (c != "T") note_error(StTz);
    end else if (pos_q >= DateLen) begin
      note_error(StTz);
    end
    count = int'(pos_q) + 1;
    pos_q = (count > int'(PosSat)) ? PosSat : PosW'(count);
    if (last) begin
      st  = (count < int'(DateLen)) ? StShort : err_q;
      res = '0;
      res.status = st;
      if (st == StOk) begin
        res.year   = year_q;
        res.month  = mon_found_q;
        res.day    = fld_q[0];
        res.hour   = fld_q[1];
        res.minute = fld_q[2];
        res.second = fld_q[3];
      end
      date_q.push_back(res);
      clear_parse();
    end
  endtask

  task automatic send_char(input logic [CharW-1:0] c, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_byte_i <= c;
    last_char_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    parse_char(c, last);
    chars_sent++;
  endtask

  task automatic send_chars(input char_q_t q);
    foreach (q[i]) send_char(q[i], i == q.size() - 1);
  endtask

  function automatic char_q_t to_chars(input string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (date_q.size() != 0);
  endtask

  function automatic logic [CharW-1:0] rand_digit();
    return CharW'(8'h30 + $urandom_range(0, 9));
  endfunction

  // well-formed date with random weekday bytes and random digits
  function automatic char_q_t random_date();
    char_q_t q;
    logic [23:0] mon;
    mon = month_names[$urandom_range(0, 11)];
    for (int i = 0; i < 3; i++) q.push_back(CharW'($urandom_range(0, 255)));
    q.push_back(","); q.push_back(" ");
    q.push_back(rand_digit()); q.push_back(rand_digit()); q.push_back(" ");
    q.push_back(mon[23:16]); q.push_back(mon[15:8]); q.push_back(mon[7:0]);
    q.push_back(" ");
    for (int i = 0; i < 4; i++) q.push_back(rand_digit());
    q.push_back(" ");
    q.push_back(rand_digit()); q.push_back(rand_digit()); q.push_back(":");
    q.push_back(rand_digit()); q.push_back(rand_digit()); q.push_back(":");
    q.push_back(rand_digit()); q.push_back(rand_digit()); q.push_back(" ");
    q.push_back("G"); q.push_back("M"); q.push_back("T");
    return q;
  endfunction

  task automatic test_valid_dates();
    char_q_t q;
    send_chars(to_chars("Sun, 06 Nov 1994 08:49:37 GMT"));
    q = to_chars("Mon, 00 Jan 0000 00:00:00 GMT");
    q[0] = 8'h00;
    q[1] = 8'hFF;
    send_chars(q);
    send_chars(to_chars("Xyz, 99 Dec 9999 99:99:99 GMT"));
    for (int m = 0; m < 12; m++) begin
      q = random_date();
      {q[8], q[9], q[10]} = month_names[m];
      send_chars(q);
    end
  endtask

  task automatic test_format_errors();
    char_q_t q;
    // too short, single word and short with an earlier error
    send_char("S", 1'b1);
    send_chars(to_chars("Sun; 06"));
    send_chars(to_chars("Sun, 06 Nov 1994 08:49:37 GM"));
    // missing comma or space
    send_chars(to_chars("Sun. 06 Nov 1994 08:49:37 GMT"));
    send_chars(to_chars("Sun,_06 Nov 1994 08:49:37 GMT"));
    // month name is case sensitive, and an unknown name is an error
    send_chars(to_chars("Sun, 06 nov 1994 08:49:37 GMT"));
    send_chars(to_chars("Sun, 06 Nox 1994 08:49:37 GMT"));
    // non-digit in each numeric field
    send_chars(to_chars("Sun, 0/ Nov 1994 08:49:37 GMT"));
    send_chars(to_chars("Sun, 06 Nov 19:4 08:49:37 GMT"));
    send_chars(to_chars("Sun, 06 Nov 1994 A8:49:37 GMT"));
    send_chars(to_chars("Sun, 06 Nov 1994 08:4 :37 GMT"));
    send_chars(to_chars("Sun, 06 Nov 1994 08:49:3a GMT"));
    // wrong zone
    send_chars(to_chars("Sun, 06 Nov 1994 08:49:37 GMX"));
    send_chars(to_chars("Sun, 06 Nov 1994 08:49:37 UTC"));
    // several errors, lowest position wins
    send_chars(to_chars("Sun; 0x Foo 19x4 08:49:37 PST"));
    send_chars(to_chars("Sun, 06 Foo 1x94 08:49:37 GMT"));
  endtask

  task automatic test_long_strings();
    char_q_t q;
    q = to_chars("Sun, 06 Nov 1994 08:49:37 GMT");
    q.push_back("Z");
    send_chars(q);
    // tail long enough to saturate the byte counter
    for (int i = 0; i < 12; i++) q.push_back(CharW'($urandom_range(0, 255)));
    send_chars(q);
    send_chars(random_date());
  endtask

  task automatic test_random_dates();
    char_q_t q;
    int      start;
    int      kind;
    int      len;
    bit      paused;
    start  = chars_sent;
    paused = 1'b0;
    while (chars_sent - start < 600) begin
      no_idle = ($urandom_range(0, 7) == 0);
      kind    = $urandom_range(0, 19);
      if (kind < 16) begin
        q = random_date();
        case ($urandom_range(0, 9))
          6, 7: q[$urandom_range(0, 28)] = CharW'($urandom_range(0, 255));
          8: begin
            len = $urandom_range(1, 28);
            while (q.size() > len) void'(q.pop_back());
          end
          9: repeat ($urandom_range(1, 6)) q.push_back(CharW'($urandom_range(0, 255)));
          default: ;
        endcase
      end else begin
        q.delete();
        len = $urandom_range(1, 36);
        repeat (len) q.push_back(CharW'($urandom_range(0, 255)));
      end
      send_chars(q);
      if (!paused && chars_sent - start > 300) begin
        wait_all_results();
        paused = 1'b1;
      end
    end
    no_idle = 1'b0;
  endtask

  // result side: draws a stall per word, then holds ready until a word is taken
  initial begin
    int stall;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (date_q.size() == 0) begin
        $error("result word with no date pending");
        errors++;
      end else begin
        want = date_q.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
        if (year_value_o !== want.year) begin
          $error("year_value: expected %0d, got %0d", want.year, year_value_o);
          errors++;
        end
        if (month_value_o !== want.month) begin
          $error("month_value: expected %0d, got %0d", want.month, month_value_o);
          errors++;
        end
        if (day_value_o !== want.day) begin
          $error("day_value: expected %0d, got %0d", want.day, day_value_o);
          errors++;
        end
        if (hour_value_o !== want.hour) begin
          $error("hour_value: expected %0d, got %0d", want.hour, hour_value_o);
          errors++;
        end
        if (minute_value_o !== want.minute) begin
          $error("minute_value: expected %0d, got %0d", want.minute, minute_value_o);
          errors++;
        end
        if (second_value_o !== want.second) begin
          $error("second_value: expected %0d, got %0d", want.second, second_value_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    clear_parse();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_valid_dates();
    test_format_errors();
    test_long_strings();
    test_random_dates();
    wait_all_results();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/hdp_pkg.sv
src/hdp_core.sv
src/http_date_parser.sv
bench/http_date_parser_tb.sv
